>>> hw/rtl/lfsm_pkg.sv
// ----------------------------------------------------------------------------
// lfsm_pkg
// Shared types and codes for the LED feedback sequencer.
// ----------------------------------------------------------------------------
package lfsm_pkg;

  // input operations (s_tuser)
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_PRESENCE = 3'd1;
  localparam logic [2:0] OP_SUCCESS  = 3'd2;
  localparam logic [2:0] OP_ERROR    = 3'd3;
  localparam logic [2:0] OP_BUSY     = 3'd4;
  localparam logic [2:0] OP_STANDBY  = 3'd5;

  // result actions (m_tuser)
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_SOLID = 3'd1;
  localparam logic [2:0] ACT_BLINK = 3'd2;
  localparam logic [2:0] ACT_CLEAR = 3'd3;
  localparam logic [2:0] ACT_FRAME = 3'd4;

  // modes
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_BLINK   = 2'd1;
  localparam logic [1:0] MODE_SUCCESS = 2'd2;
  localparam logic [1:0] MODE_ERROR   = 2'd3;

  // register indexes
  localparam logic [2:0] REG_TIMEOUT   = 3'd0;
  localparam logic [2:0] REG_SUCC_COL  = 3'd1;
  localparam logic [2:0] REG_ERR_COL   = 3'd2;
  localparam logic [2:0] REG_BLINK_EN  = 3'd3;
  localparam logic [2:0] REG_BLINK_CNT = 3'd4;
  localparam logic [2:0] REG_BLINK_HALF = 3'd5;

  localparam int unsigned ADDR_W = 5;

  // timing constants in ms, and the blink count limit MAX_BLINKS
  localparam int unsigned GRACE_MS    = 200;
  localparam int unsigned REFRESH_MS  = 25;
  localparam int unsigned MIN_HALF_MS = 25;
  localparam int unsigned BLOCK_MS    = 2;
  localparam int unsigned MAX_BLINKS  = 10;
  localparam int unsigned DEBOUNCE_MS = 200;
  localparam int unsigned FRAME_MS    = 25;

  // blink half-period index, up to twice MAX_BLINKS
  localparam int unsigned BLINK_IV_W = 5;

  typedef struct packed {
    logic [19:0] linger_ms;
    logic [23:0] success_color;
    logic [23:0] error_color;
    logic        blink_enable;
    logic [3:0]  blink_count;
    logic [15:0] blink_half_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [23:0] color;
    logic [31:0] frame_time;
    logic [1:0]  mode;
  } res_t;

endpackage

>>> hw/rtl/lfsm_cfg.sv
// ----------------------------------------------------------------------------
// lfsm_cfg
// Register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module lfsm_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfsm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output lfsm_pkg::cfg_t              cfg
);

  logic [2:0] reg_idx;
  logic       wr_en;
  logic [3:0] cnt_clamped;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cnt_clamped = (pwdata[3:0] > 4'(lfsm_pkg::MAX_BLINKS)) ?
                       4'(lfsm_pkg::MAX_BLINKS) : pwdata[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.linger_ms     <= 20'd6000;
      cfg.success_color <= 24'h00FF00;
      cfg.error_color   <= 24'hFF0000;
      cfg.blink_enable  <= 1'b1;
      cfg.blink_count   <= 4'd3;
      cfg.blink_half_ms <= 16'd150;
    end else if (wr_en) begin
      case (reg_idx)
        lfsm_pkg::REG_TIMEOUT:    cfg.linger_ms     <= pwdata[19:0];
        lfsm_pkg::REG_SUCC_COL:   cfg.success_color <= pwdata[23:0];
        lfsm_pkg::REG_ERR_COL:    cfg.error_color   <= pwdata[23:0];
        lfsm_pkg::REG_BLINK_EN:   cfg.blink_enable  <= pwdata[0];
        lfsm_pkg::REG_BLINK_CNT:  cfg.blink_count   <= cnt_clamped;
        lfsm_pkg::REG_BLINK_HALF: cfg.blink_half_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lfsm_pkg::REG_TIMEOUT:    prdata = 32'(cfg.linger_ms);
      lfsm_pkg::REG_SUCC_COL:   prdata = 32'(cfg.success_color);
      lfsm_pkg::REG_ERR_COL:    prdata = 32'(cfg.error_color);
      lfsm_pkg::REG_BLINK_EN:   prdata = 32'(cfg.blink_enable);
      lfsm_pkg::REG_BLINK_CNT:  prdata = 32'(cfg.blink_count);
      lfsm_pkg::REG_BLINK_HALF: prdata = 32'(cfg.blink_half_ms);
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

>>> hw/rtl/lfsm_core.sv
// ----------------------------------------------------------------------------
// lfsm_core
// Sequencer state and the next-state / result logic for one item.
// ----------------------------------------------------------------------------
module lfsm_core #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  logic [2:0]     operation,
  input  logic           present,
  input  logic [15:0]    pause_ms,
  input  logic           standby_on,
  input  lfsm_pkg::cfg_t cfg,
  output lfsm_pkg::res_t res
);

  localparam int unsigned IW = lfsm_pkg::BLINK_IV_W;

  logic [TIME_BITS-1:0] time_now, time_now_next;
  logic [1:0]           mode_reg, mode_reg_next;
  logic                 tag_held, tag_held_next;
  logic [TIME_BITS-1:0] last_seen_time, last_seen_time_next;
  logic [TIME_BITS-1:0] release_time, release_time_next;
  logic                 hold_active, hold_active_next;
  logic [23:0]          hold_color, hold_color_next;
  logic [TIME_BITS-1:0] last_refresh_time, last_refresh_time_next;
  logic [15:0]          blink_period_used, blink_period_used_next;
  logic [15:0]          blink_sub, blink_sub_next;   // ms into current half period
  logic [IW-1:0]        blink_iv, blink_iv_next;     // half periods elapsed
  logic [TIME_BITS-1:0] last_success_time, last_success_time_next;
  logic [TIME_BITS-1:0] idle_block_until, idle_block_until_next;
  logic [TIME_BITS-1:0] busy_pause_until, busy_pause_until_next;
  logic [TIME_BITS-1:0] last_pulse_time, last_pulse_time_next;
  logic                 standby_flag, standby_flag_next;
  logic                 pulse_enabled, pulse_enabled_next;

  logic [TIME_BITS-1:0] tick_now;
  logic [TIME_BITS-1:0] since_release;
  logic                 timed_out;
  logic                 refresh_due;
  logic [16:0]          sub_inc;
  logic                 blink_wrap;
  logic [IW-1:0]        iv_inc;
  logic                 blink_done;
  logic                 idle_blocked;
  logic                 frame_due;
  logic [TIME_BITS-1:0] pulse_step;
  logic                 seen_stale;
  logic                 success_early;
  logic [TIME_BITS-1:0] busy_until;
  logic [15:0]          half_used;
  logic [63:0]          pulse_wide;
  logic                 is_solid;

  assign tick_now    = time_now + TIME_BITS'(1);
  assign is_solid    = (mode_reg == lfsm_pkg::MODE_SUCCESS) ||
                       (mode_reg == lfsm_pkg::MODE_ERROR);
  // elapsed time wraps at TIME_BITS before it is compared
  assign since_release = tick_now - release_time;
  assign timed_out   = (release_time != '0) &&
                       (64'(since_release) >= 64'(cfg.linger_ms));
  assign refresh_due = (tick_now - last_refresh_time) >= TIME_BITS'(lfsm_pkg::REFRESH_MS);
  assign sub_inc     = {1'b0, blink_sub} + 17'd1;
  assign blink_wrap  = sub_inc == {1'b0, blink_period_used};
  assign iv_inc      = blink_iv + IW'(blink_wrap);
  assign blink_done  = iv_inc >= {1'b0, cfg.blink_count} << 1;
  assign idle_blocked = (tick_now < idle_block_until) || (tick_now < busy_pause_until);
  assign frame_due   = (tick_now - last_pulse_time) >= TIME_BITS'(lfsm_pkg::FRAME_MS);
  assign pulse_step  = last_pulse_time + TIME_BITS'(lfsm_pkg::FRAME_MS);
  assign pulse_wide  = 64'(pulse_step);
  assign seen_stale  = (time_now - last_seen_time) > TIME_BITS'(lfsm_pkg::GRACE_MS);
  assign success_early = (time_now - last_success_time) <
                         TIME_BITS'(lfsm_pkg::DEBOUNCE_MS);
  assign busy_until  = time_now + TIME_BITS'(pause_ms);
  assign half_used   = (cfg.blink_half_ms < 16'(lfsm_pkg::MIN_HALF_MS)) ?
                       16'(lfsm_pkg::MIN_HALF_MS) : cfg.blink_half_ms;

  always_comb begin
    time_now_next          = time_now;
    mode_reg_next          = mode_reg;
    tag_held_next          = tag_held;
    last_seen_time_next    = last_seen_time;
    release_time_next      = release_time;
    hold_active_next       = hold_active;
    hold_color_next        = hold_color;
    last_refresh_time_next = last_refresh_time;
    blink_period_used_next = blink_period_used;
    blink_sub_next         = blink_sub;
    blink_iv_next          = blink_iv;
    last_success_time_next = last_success_time;
    idle_block_until_next  = idle_block_until;
    busy_pause_until_next  = busy_pause_until;
    last_pulse_time_next   = last_pulse_time;
    standby_flag_next      = standby_flag;
    pulse_enabled_next     = pulse_enabled;
    res.action             = lfsm_pkg::ACT_NONE;
    res.color              = 24'd0;
    res.frame_time         = 32'd0;

    case (operation)
      lfsm_pkg::OP_TICK: begin
        time_now_next = tick_now;
        if (!standby_flag) begin
          if (is_solid) begin
            if (tag_held) begin
              release_time_next = '0;
            end
            if (!tag_held && timed_out) begin
              mode_reg_next         = lfsm_pkg::MODE_OFF;
              hold_active_next      = 1'b0;
              release_time_next     = '0;
              last_pulse_time_next  = tick_now - TIME_BITS'(lfsm_pkg::FRAME_MS);
              idle_block_until_next = tick_now + TIME_BITS'(lfsm_pkg::BLOCK_MS);
            end else if (hold_active && refresh_due) begin
              last_refresh_time_next = tick_now;
              res.action             = lfsm_pkg::ACT_SOLID;
              res.color              = hold_color;
            end
          end else if (mode_reg == lfsm_pkg::MODE_BLINK) begin
            blink_sub_next = blink_wrap ? 16'd0 : sub_inc[15:0];
            blink_iv_next  = iv_inc;
            if (blink_wrap) begin
              res.action = lfsm_pkg::ACT_BLINK;
              res.color  = iv_inc[0] ? 24'd0 : cfg.success_color;
            end
            if (blink_done) begin
              // last edge and the switch to solid land together
              mode_reg_next          = lfsm_pkg::MODE_SUCCESS;
              hold_active_next       = 1'b1;
              hold_color_next        = cfg.success_color;
              last_refresh_time_next = '0;
              release_time_next      = tag_held ? '0 : tick_now;
              idle_block_until_next  = tick_now + TIME_BITS'(lfsm_pkg::BLOCK_MS);
              res.action             = lfsm_pkg::ACT_SOLID;
              res.color              = cfg.success_color;
            end
          end else if (!idle_blocked && frame_due) begin
            last_pulse_time_next = pulse_step;
            if (pulse_enabled) begin
              res.action     = lfsm_pkg::ACT_FRAME;
              res.frame_time = pulse_wide[31:0];
            end
          end
        end
      end

      lfsm_pkg::OP_PRESENCE: begin
        if (standby_flag && present) begin
          standby_flag_next     = 1'b0;
          pulse_enabled_next    = 1'b1;
          last_pulse_time_next  = time_now;
          idle_block_until_next = time_now + TIME_BITS'(lfsm_pkg::BLOCK_MS);
        end
        if (present) begin
          last_seen_time_next = time_now;
          if (!tag_held) begin
            tag_held_next     = 1'b1;
            release_time_next = '0;
          end
        end else if (tag_held && seen_stale) begin
          tag_held_next     = 1'b0;
          release_time_next = is_solid ? time_now : '0;
        end
      end

      lfsm_pkg::OP_SUCCESS: begin
        if (!success_early) begin
          last_success_time_next = time_now;
          if (cfg.blink_enable && (cfg.blink_count != 4'd0) &&
              (mode_reg != lfsm_pkg::MODE_BLINK)) begin
            blink_period_used_next = half_used;
            mode_reg_next          = lfsm_pkg::MODE_BLINK;
            blink_sub_next         = 16'd0;
            blink_iv_next          = '0;
            hold_active_next       = 1'b0;
            release_time_next      = '0;
            res.action             = lfsm_pkg::ACT_BLINK;
            res.color              = cfg.success_color;
          end else begin
            mode_reg_next          = lfsm_pkg::MODE_SUCCESS;
            hold_active_next       = 1'b1;
            hold_color_next        = cfg.success_color;
            last_refresh_time_next = '0;
            release_time_next      = tag_held ? '0 : time_now;
            res.action             = lfsm_pkg::ACT_SOLID;
            res.color              = cfg.success_color;
          end
        end
      end

      lfsm_pkg::OP_ERROR: begin
        mode_reg_next          = lfsm_pkg::MODE_ERROR;
        hold_active_next       = 1'b1;
        hold_color_next        = cfg.error_color;
        last_refresh_time_next = '0;
        release_time_next      = tag_held ? '0 : time_now;
        idle_block_until_next  = time_now + TIME_BITS'(lfsm_pkg::BLOCK_MS);
        res.action             = lfsm_pkg::ACT_SOLID;
        res.color              = cfg.error_color;
      end

      lfsm_pkg::OP_BUSY: begin
        if (busy_until > busy_pause_until) begin
          busy_pause_until_next = busy_until;
        end
      end

      lfsm_pkg::OP_STANDBY: begin
        if (standby_on != standby_flag) begin
          if (standby_on) begin
            standby_flag_next     = 1'b1;
            pulse_enabled_next    = 1'b0;
            hold_active_next      = 1'b0;
            tag_held_next         = 1'b0;
            release_time_next     = '0;
            mode_reg_next         = lfsm_pkg::MODE_OFF;
            idle_block_until_next = '0;
            last_pulse_time_next  = time_now - TIME_BITS'(lfsm_pkg::FRAME_MS);
            res.action            = lfsm_pkg::ACT_CLEAR;
          end else begin
            standby_flag_next     = 1'b0;
            pulse_enabled_next    = 1'b1;
            last_pulse_time_next  = time_now;
            idle_block_until_next = time_now + TIME_BITS'(lfsm_pkg::BLOCK_MS);
          end
        end
      end

      default: ;
    endcase

    res.mode = mode_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now          <= '0;
      mode_reg          <= lfsm_pkg::MODE_OFF;
      tag_held          <= 1'b0;
      last_seen_time    <= '0;
      release_time      <= '0;
      hold_active       <= 1'b0;
      hold_color        <= 24'd0;
      last_refresh_time <= '0;
      blink_period_used <= 16'd150;
      blink_sub         <= 16'd0;
      blink_iv          <= '0;
      last_success_time <= '0;
      idle_block_until  <= '0;
      busy_pause_until  <= '0;
      last_pulse_time   <= '0;
      standby_flag      <= 1'b0;
      pulse_enabled     <= 1'b1;
    end else if (fire) begin
      time_now          <= time_now_next;
      mode_reg          <= mode_reg_next;
      tag_held          <= tag_held_next;
      last_seen_time    <= last_seen_time_next;
      release_time      <= release_time_next;
      hold_active       <= hold_active_next;
      hold_color        <= hold_color_next;
      last_refresh_time <= last_refresh_time_next;
      blink_period_used <= blink_period_used_next;
      blink_sub         <= blink_sub_next;
      blink_iv          <= blink_iv_next;
      last_success_time <= last_success_time_next;
      idle_block_until  <= idle_block_until_next;
      busy_pause_until  <= busy_pause_until_next;
      last_pulse_time   <= last_pulse_time_next;
      standby_flag      <= standby_flag_next;
      pulse_enabled     <= pulse_enabled_next;
    end
  end

endmodule

>>> hw/rtl/led_feedback_state_machine.sv
// ----------------------------------------------------------------------------
// led_feedback_state_machine
// Status LED sequencer for a tag reader: one action per input item.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle unless the result side stalls, and returns
// exactly one result per item. An accepted item sits in an input register
// until the sequencer logic updates its state and loads the result register,
// which then offers the result on the m_ side. Both registers move
// together: the input side keeps accepting while the result register is
// free or being drained, and one more item is taken while a result waits.
// The blink phase is tracked by a per-millisecond counter and a half-period
// index instead of a divider, so every item is one pass through short logic.
// Configuration goes through the APB-style port (register i at byte 4*i)
// and must only be changed while no item is in flight. Nothing needs a
// clearing pass after reset: rst clears all but the item and result data.
// ----------------------------------------------------------------------------
module led_feedback_state_machine #(
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  // input items
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,   // present[0], pause_ms[16:1],
                                                 // standby_on[17], zero pad
  input  logic [2:0]                  s_tuser,   // operation[2:0]
  // result items
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [63:0]                 m_tdata,   // color[23:0], frame_time[55:24],
                                                 // mode[57:56], zero pad
  output logic [2:0]                  m_tuser,   // action[2:0]
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfsm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  lfsm_pkg::cfg_t cfg;
  lfsm_pkg::res_t res;
  lfsm_pkg::res_t out_res;

  // input register
  logic        in_valid;
  logic [2:0]  in_op;
  logic        in_present;
  logic [15:0] in_pause;
  logic        in_standby;

  logic out_free;   // result register empty or draining this cycle
  logic fire;       // item in the input register is processed
  logic take;       // new item accepted

  assign out_free = !m_tvalid || m_tready;
  assign fire     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_op      <= s_tuser;
      in_present <= s_tdata[0];
      in_pause   <= s_tdata[16:1];
      in_standby <= s_tdata[17];
    end
  end

  lfsm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lfsm_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .operation  (in_op),
    .present    (in_present),
    .pause_ms   (in_pause),
    .standby_on (in_standby),
    .cfg        (cfg),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.action;
  assign m_tdata = {6'd0, out_res.mode, out_res.frame_time, out_res.color};

endmodule

>>> hw/rtl/lfsm_checker.sv
// ----------------------------------------------------------------------------
// lfsm_checker
// Port-level checks on the result stream of the LED sequencer.
// ----------------------------------------------------------------------------
module lfsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [2:0]  m_tuser
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // no result right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // idle frames and clears only happen with the strip off and carry no colour
  a_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == lfsm_pkg::ACT_FRAME || m_tuser == lfsm_pkg::ACT_CLEAR)
    |-> m_tdata[57:56] == lfsm_pkg::MODE_OFF && m_tdata[23:0] == 24'd0)
    else $error("idle frame or clear outside off mode");

  // time stamp only on idle frames
  a_stamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != lfsm_pkg::ACT_FRAME |-> m_tdata[55:24] == 32'd0)
    else $error("frame time on a non-frame action");

endmodule

bind led_feedback_state_machine lfsm_checker u_lfsm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
